[rtl/segscan_pkg.sv]
// shared constants, types and the segment font for the seven-segment scanner
package segscan_pkg;

   localparam int MAX_DIGITS = 8;
   localparam int DIGIT_W    = $clog2(MAX_DIGITS);
   localparam int COUNT_W    = $clog2(MAX_DIGITS + 1);
   localparam int HALF_W     = 16;
   localparam int BLINK_W    = HALF_W + 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = HALF_W;
   localparam int SEG_W      = 7;
   localparam int BCD_W      = 4;

   // request commands
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DIGIT_COUNT       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BLINK_DIGIT_FIRST = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BLINK_DIGIT_LAST  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BLINK_DIGIT_HALF  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BLINK_POINT_FIRST = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BLINK_POINT_LAST  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BLINK_POINT_HALF  = 3'd6;

   localparam logic [COUNT_W-1:0] DIGIT_COUNT_RESET = COUNT_W'(MAX_DIGITS);

   typedef struct packed {
      logic [SEG_W-1:0]   segments;
      logic               point;
      logic [DIGIT_W-1:0] digit;
   } rsp_type;

   // bit 0 is segment a, values above 9 are blank
   function automatic logic [SEG_W-1:0] seg_font(input logic [BCD_W-1:0] bcd);
      logic [SEG_W-1:0] pattern;
      case (bcd)
         4'd0:    pattern = 7'h3F;
         4'd1:    pattern = 7'h06;
         4'd2:    pattern = 7'h5B;
         4'd3:    pattern = 7'h4F;
         4'd4:    pattern = 7'h66;
         4'd5:    pattern = 7'h6D;
         4'd6:    pattern = 7'h7D;
         4'd7:    pattern = 7'h07;
         4'd8:    pattern = 7'h7F;
         4'd9:    pattern = 7'h6F;
         default: pattern = '0;
      endcase
      return pattern;
   endfunction

endpackage

[rtl/mux_seven_segment_blink_scanner.sv]
// top level of the multiplexed seven-segment scanner with digit and point blinking
// a tick result is registered in the output register, or first in the skid register if stalled
// throughput: one request per cycle without req_stall; store, scan and blink are a single pass
// while rsp_stall holds a result, one more tick request goes to a skid register, then req_stall
// reset: synchronous, clears stores, scan position, blink counters and registers
// (digit count returns to 8), and empties the output and skid registers
module mux_seven_segment_blink_scanner (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic [segscan_pkg::DIGIT_W-1:0]     req_write_index,
   input  logic [segscan_pkg::BCD_W-1:0]       req_bcd_value,
   input  logic                                req_point_on,
   input  logic                                req_clear_first,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [segscan_pkg::SEG_W-1:0]       rsp_segments_out,
   output logic                                rsp_point_out,
   output logic [segscan_pkg::DIGIT_W-1:0]     rsp_active_digit,
   input  logic                                csr_write,
   input  logic [segscan_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [segscan_pkg::CSR_DATA_W-1:0]  csr_data
);
   import segscan_pkg::*;

   // configuration
   logic [COUNT_W-1:0] digit_count_ff, digit_count_in;
   logic [DIGIT_W-1:0] dig_first_ff, dig_first_in;
   logic [DIGIT_W-1:0] dig_last_ff, dig_last_in;
   logic [HALF_W-1:0]  dig_half_ff, dig_half_in;
   logic [DIGIT_W-1:0] pt_first_ff, pt_first_in;
   logic [DIGIT_W-1:0] pt_last_ff, pt_last_in;
   logic [HALF_W-1:0]  pt_half_ff, pt_half_in;

   // display state
   logic [MAX_DIGITS-1:0][SEG_W-1:0] seg_store_ff, seg_store_in;
   logic [MAX_DIGITS-1:0]            pt_store_ff, pt_store_in;
   logic [DIGIT_W-1:0]               scan_ff, scan_in;
   logic [BLINK_W-1:0]               dig_cnt_ff, dig_cnt_in;
   logic [BLINK_W-1:0]               pt_cnt_ff, pt_cnt_in;

   // result path
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type skid_ff, skid_in;
   logic    skid_valid_ff, skid_valid_in;

   logic               req_accept;
   logic [COUNT_W-1:0] n_active;
   logic [COUNT_W-1:0] pos_inc;
   logic [DIGIT_W-1:0] pos_next;
   logic [COUNT_W-1:0] wr_slot_full;
   logic [DIGIT_W-1:0] wr_slot;
   logic [BLINK_W:0]   dig_cnt_plus;
   logic [BLINK_W:0]   pt_cnt_plus;
   logic [BLINK_W-1:0] dig_cnt_step;
   logic [BLINK_W-1:0] pt_cnt_step;
   logic               dig_blank;
   logic               pt_blank;
   rsp_type            new_rsp;
   logic               new_rsp_valid;
   logic               out_free;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = skid_valid_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_segments_out = rsp_ff.segments;
   assign rsp_point_out    = rsp_ff.point;
   assign rsp_active_digit = rsp_ff.digit;

   // scanned digit count saturated to 1..MAX_DIGITS
   always_comb begin
      if (digit_count_ff == '0) begin
         n_active = COUNT_W'(1);
      end else if (digit_count_ff > COUNT_W'(MAX_DIGITS)) begin
         n_active = COUNT_W'(MAX_DIGITS);
      end else begin
         n_active = digit_count_ff;
      end
   end

   assign pos_inc  = {1'b0, scan_ff} + COUNT_W'(1);
   assign pos_next = (pos_inc >= n_active) ? '0 : pos_inc[DIGIT_W-1:0];

   // segments go to the mirrored slot, points stay at the written index
   assign wr_slot_full = n_active - COUNT_W'(1) - {1'b0, req_write_index};
   assign wr_slot      = wr_slot_full[DIGIT_W-1:0];

   assign dig_cnt_plus = {1'b0, dig_cnt_ff} + (BLINK_W+1)'(1);
   assign pt_cnt_plus  = {1'b0, pt_cnt_ff} + (BLINK_W+1)'(1);
   assign dig_cnt_step = (dig_cnt_plus >= {1'b0, dig_half_ff, 1'b0}) ? '0
                         : dig_cnt_plus[BLINK_W-1:0];
   assign pt_cnt_step  = (pt_cnt_plus >= {1'b0, pt_half_ff, 1'b0}) ? '0
                         : pt_cnt_plus[BLINK_W-1:0];

   always_comb begin
      seg_store_in  = seg_store_ff;
      pt_store_in   = pt_store_ff;
      scan_in       = scan_ff;
      dig_cnt_in    = dig_cnt_ff;
      pt_cnt_in     = pt_cnt_ff;
      new_rsp_valid = 1'b0;

      if (req_accept && req_cmd == CMD_WRITE) begin
         if (req_clear_first) begin
            seg_store_in = '0;
            pt_store_in  = '0;
         end
         if ({1'b0, req_write_index} < n_active) begin
            seg_store_in[wr_slot]         = seg_font(req_bcd_value);
            pt_store_in[req_write_index]  = req_point_on;
         end
      end else if (req_accept) begin
         scan_in       = pos_next;
         new_rsp_valid = 1'b1;
         // blink counters with a nonzero half period step once per frame, when the scan wraps
         if (pos_next == '0) begin
            if (dig_half_ff != '0) begin
               dig_cnt_in = dig_cnt_step;
            end
            if (pt_half_ff != '0) begin
               pt_cnt_in = pt_cnt_step;
            end
         end
      end

      digit_count_in = digit_count_ff;
      dig_first_in   = dig_first_ff;
      dig_last_in    = dig_last_ff;
      dig_half_in    = dig_half_ff;
      pt_first_in    = pt_first_ff;
      pt_last_in     = pt_last_ff;
      pt_half_in     = pt_half_ff;
      if (csr_write) begin
         case (csr_index)
            REG_DIGIT_COUNT: begin
               digit_count_in = csr_data[COUNT_W-1:0];
            end
            REG_BLINK_DIGIT_FIRST: begin
               dig_first_in = csr_data[DIGIT_W-1:0];
               dig_cnt_in   = '0;
            end
            REG_BLINK_DIGIT_LAST: begin
               dig_last_in = csr_data[DIGIT_W-1:0];
               dig_cnt_in  = '0;
            end
            REG_BLINK_DIGIT_HALF: begin
               dig_half_in = csr_data[HALF_W-1:0];
               dig_cnt_in  = '0;
            end
            REG_BLINK_POINT_FIRST: begin
               pt_first_in = csr_data[DIGIT_W-1:0];
               pt_cnt_in   = '0;
            end
            REG_BLINK_POINT_LAST: begin
               pt_last_in = csr_data[DIGIT_W-1:0];
               pt_cnt_in  = '0;
            end
            REG_BLINK_POINT_HALF: begin
               pt_half_in = csr_data[HALF_W-1:0];
               pt_cnt_in  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // blanking uses the counter value after this tick's step
   assign dig_blank = (dig_half_ff != '0) && (dig_cnt_in < {1'b0, dig_half_ff})
                      && (pos_next >= dig_first_ff) && (pos_next <= dig_last_ff);
   assign pt_blank  = (pt_half_ff != '0) && (pt_cnt_in < {1'b0, pt_half_ff})
                      && (pos_next >= pt_first_ff) && (pos_next <= pt_last_ff);

   always_comb begin
      new_rsp.segments = dig_blank ? '0 : seg_store_ff[pos_next];
      new_rsp.point    = pt_blank ? 1'b0 : pt_store_ff[pos_next];
      new_rsp.digit    = pos_next;
   end

   // output register with a skid stage behind it
   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_in        = skid_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (new_rsp_valid) begin
            rsp_in       = new_rsp;
            rsp_valid_in = 1'b1;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (new_rsp_valid) begin
         skid_in       = new_rsp;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff <= DIGIT_COUNT_RESET;
         dig_first_ff   <= '0;
         dig_last_ff    <= '0;
         dig_half_ff    <= '0;
         pt_first_ff    <= '0;
         pt_last_ff     <= '0;
         pt_half_ff     <= '0;
         seg_store_ff   <= '0;
         pt_store_ff    <= '0;
         scan_ff        <= '0;
         dig_cnt_ff     <= '0;
         pt_cnt_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         digit_count_ff <= digit_count_in;
         dig_first_ff   <= dig_first_in;
         dig_last_ff    <= dig_last_in;
         dig_half_ff    <= dig_half_in;
         pt_first_ff    <= pt_first_in;
         pt_last_ff     <= pt_last_in;
         pt_half_ff     <= pt_half_in;
         seg_store_ff   <= seg_store_in;
         pt_store_ff    <= pt_store_in;
         scan_ff        <= scan_in;
         dig_cnt_ff     <= dig_cnt_in;
         pt_cnt_ff      <= pt_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

endmodule

[rtl/segscan_checker.sv]
// port-level checks for the seven-segment scanner and their bind to the top level
module segscan_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_cmd,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [segscan_pkg::SEG_W-1:0]       rsp_segments_out,
   input logic                                rsp_point_out,
   input logic [segscan_pkg::DIGIT_W-1:0]     rsp_active_digit
);
   import segscan_pkg::*;

   // no result pending and no request stall right after reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("result or stall present after reset");

   // with the output empty a tick request shows up on the next cycle
   a_tick_result : assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && req_valid && !req_stall && req_cmd == CMD_TICK) |=> rsp_valid)
      else $error("tick request did not produce a result");

   // a write request never produces a result
   a_write_silent : assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && req_valid && !req_stall && req_cmd == CMD_WRITE) |=> !rsp_valid)
      else $error("write request produced a result");

   // input stalls only while a result is held back at the output
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("request stall without a stalled result");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_segments_out)
                                    && $stable(rsp_point_out) && $stable(rsp_active_digit)))
      else $error("stalled result changed");

endmodule

bind mux_seven_segment_blink_scanner segscan_checker u_segscan_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_cmd          (req_cmd),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_segments_out (rsp_segments_out),
   .rsp_point_out    (rsp_point_out),
   .rsp_active_digit (rsp_active_digit)
);
